/* sv/pldr_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register codes and controller/datapath interface types of the recorder.
package pldr_pkg;

   localparam int PRESSURE_W = 17;
   localparam int STEP_W     = 8;
   localparam int QUOT_W     = 16;
   localparam int ALT_W      = 16;
   localparam int COUNT_W    = 16;
   localparam int DELTA_W    = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0]  PRESSURE_STEP_RESET     = 8'd18;
   localparam logic [STEP_W-1:0]  START_THRESHOLD_RESET   = 8'd3;
   localparam logic [COUNT_W-1:0] FAST_RECORD_COUNT_RESET = 16'd80;
   localparam logic [COUNT_W-1:0] STORE_CAPACITY_RESET    = 16'd512;

   typedef enum logic [1:0] {
      CSR_PRESSURE_STEP,
      CSR_START_THRESHOLD,
      CSR_FAST_RECORD_COUNT,
      CSR_STORE_CAPACITY
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_PREV_TO_SAMPLE,
      OP_LAUNCH_TO_PREV,
      OP_LAUNCH_TO_SAMPLE
   } operand_sel_type;

   typedef struct packed {
      logic [STEP_W-1:0]  pressure_step;
      logic [STEP_W-1:0]  start_threshold;
      logic [COUNT_W-1:0] fast_record_count;
      logic [COUNT_W-1:0] store_capacity;
   } cfg_type;

   typedef struct packed {
      logic            load_sample;
      logic            set_reference;
      logic            slide_reference;
      logic            set_recording;
      logic            div_start;
      operand_sel_type div_operands;
      logic            emit;
      logic            emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic have_reference;
      logic recording;
      logic halted;
      logic div_done;
      logic launch_hit;
      logic out_free;
   } dp_status_type;

endpackage

/* sv/pldr_div.sv */
`timescale 1ns / 1ps
// Bit-serial signed divider: (from - to) / step, truncated toward zero, wrapped to 16 bits.
module pldr_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pldr_pkg::PRESSURE_W-1:0]  from_pressure,
   input  logic [pldr_pkg::PRESSURE_W-1:0]  to_pressure,
   input  logic [pldr_pkg::STEP_W-1:0]      divisor,
   output logic                             done,
   output logic [pldr_pkg::QUOT_W-1:0]      quotient
);
   import pldr_pkg::*;

   localparam int ITER    = PRESSURE_W;
   localparam int COUNT_B = $clog2(ITER + 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [COUNT_B-1:0]      count_ff;
   logic                    neg_ff;
   logic [PRESSURE_W-1:0]   mag_ff;
   logic [STEP_W-1:0]       rem_ff;
   logic [STEP_W-1:0]       div_ff;

   logic [PRESSURE_W:0]     diff;
   logic [PRESSURE_W:0]     diff_abs;
   logic [STEP_W:0]         rem_ext;
   logic [STEP_W:0]         rem_sub;
   logic                    fits;
   logic [QUOT_W-1:0]       mag_lo;

   assign diff     = {1'b0, from_pressure} - {1'b0, to_pressure};
   assign diff_abs = diff[PRESSURE_W] ? (~diff + 1'b1) : diff;
   assign rem_ext  = {rem_ff, mag_ff[PRESSURE_W-1]};
   assign fits     = rem_ext >= {1'b0, div_ff};
   assign rem_sub  = rem_ext - {1'b0, div_ff};
   assign mag_lo   = mag_ff[QUOT_W-1:0];

   assign done     = done_ff;
   assign quotient = neg_ff ? (~mag_lo + 1'b1) : mag_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= COUNT_B'(ITER);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == COUNT_B'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= diff[PRESSURE_W];
         mag_ff <= diff_abs[PRESSURE_W-1:0];
         rem_ff <= '0;
         div_ff <= (divisor == '0) ? STEP_W'(1) : divisor;
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[PRESSURE_W-2:0], fits};
         rem_ff <= fits ? rem_sub[STEP_W-1:0] : rem_ext[STEP_W-1:0];
      end
   end

endmodule

/* sv/pldr_datapath.sv */
`timescale 1ns / 1ps
// Recorder datapath: sample and reference registers, divider, record arithmetic, output register.
module pldr_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  pldr_pkg::ctrl_cmd_type           cmd,
   input  pldr_pkg::cfg_type                cfg,
   input  logic [pldr_pkg::PRESSURE_W-1:0]  req_pressure,
   input  logic                             rsp_tready,
   output pldr_pkg::dp_status_type          status,
   output logic                             rsp_valid,
   output logic [pldr_pkg::DELTA_W-1:0]     rsp_delta,
   output logic                             rsp_last,
   output logic                             rsp_slow,
   output logic                             rsp_full
);
   import pldr_pkg::*;

   logic [PRESSURE_W-1:0] sample_ff;
   logic [PRESSURE_W-1:0] prev_ff;
   logic [PRESSURE_W-1:0] launch_ff;
   logic                  have_ref_ff;
   logic                  recording_ff;
   logic                  halted_ff;
   logic [ALT_W-1:0]      alt_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  rsp_valid_ff;
   logic [DELTA_W-1:0]    rsp_delta_ff;
   logic                  rsp_last_ff;
   logic                  rsp_slow_ff;
   logic                  rsp_full_ff;

   logic [PRESSURE_W-1:0] div_from;
   logic [PRESSURE_W-1:0] div_to;
   logic                  div_done;
   logic [QUOT_W-1:0]     quotient;
   logic [ALT_W-1:0]      delta_wide;
   logic [DELTA_W-1:0]    delta;
   logic [ALT_W-1:0]      alt_in;
   logic [COUNT_W-1:0]    count_in;
   logic                  full_now;
   logic                  slow_now;

   always_comb begin
      case (cmd.div_operands)
         OP_PREV_TO_SAMPLE: begin
            div_from = prev_ff;
            div_to   = sample_ff;
         end
         OP_LAUNCH_TO_PREV: begin
            div_from = launch_ff;
            div_to   = prev_ff;
         end
         OP_LAUNCH_TO_SAMPLE: begin
            div_from = launch_ff;
            div_to   = sample_ff;
         end
         default: begin
            div_from = launch_ff;
            div_to   = sample_ff;
         end
      endcase
   end

   pldr_div u_div (
      .clock         (clock),
      .reset         (reset),
      .start         (cmd.div_start),
      .from_pressure (div_from),
      .to_pressure   (div_to),
      .divisor       (cfg.pressure_step),
      .done          (div_done),
      .quotient      (quotient)
   );

   // Record value is the 8-bit wrap of steps-from-launch minus running altitude.
   assign delta_wide = quotient - alt_ff;
   assign delta      = delta_wide[DELTA_W-1:0];
   assign alt_in     = alt_ff + {{(ALT_W-DELTA_W){delta[DELTA_W-1]}}, delta};
   assign count_in   = count_ff + 1'b1;
   assign full_now   = count_in >= cfg.store_capacity;
   assign slow_now   = count_in == cfg.fast_record_count;

   assign status.have_reference = have_ref_ff;
   assign status.recording      = recording_ff;
   assign status.halted         = halted_ff;
   assign status.div_done       = div_done;
   assign status.launch_hit     = $signed({quotient[QUOT_W-1], quotient})
                                  >= $signed({{(QUOT_W+1-STEP_W){1'b0}}, cfg.start_threshold});
   assign status.out_free       = !rsp_valid_ff || rsp_tready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_delta = rsp_delta_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_slow  = rsp_slow_ff;
   assign rsp_full  = rsp_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ref_ff  <= 1'b0;
         recording_ff <= 1'b0;
         halted_ff    <= 1'b0;
         alt_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.set_reference) begin
            have_ref_ff <= 1'b1;
         end
         if (cmd.set_recording) begin
            recording_ff <= 1'b1;
         end
         if (cmd.emit) begin
            alt_ff   <= alt_in;
            count_ff <= count_in;
            if (full_now) begin
               halted_ff <= 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_pressure;
      end
      if (cmd.set_reference) begin
         prev_ff   <= sample_ff;
         launch_ff <= sample_ff;
      end else if (cmd.slide_reference) begin
         prev_ff   <= sample_ff;
         launch_ff <= prev_ff;
      end
      if (cmd.emit) begin
         rsp_delta_ff <= delta;
         rsp_last_ff  <= cmd.emit_last || full_now;
         rsp_slow_ff  <= slow_now;
         rsp_full_ff  <= full_now;
      end
   end

endmodule

/* sv/pldr_ctrl.sv */
`timescale 1ns / 1ps
// Recorder controller: sequences reference setup, launch test, divisions and record emission.
module pldr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  pldr_pkg::dp_status_type status,
   output pldr_pkg::ctrl_cmd_type  cmd
);
   import pldr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_EMIT,
      ST_AFTER_FIRST
   } state_type;

   typedef enum logic [1:0] {
      PH_TEST,
      PH_RECORD,
      PH_LAUNCH_FIRST,
      PH_LAUNCH_SECOND
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.div_operands = OP_LAUNCH_TO_SAMPLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_sample = 1'b1;
               state_in        = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.halted) begin
               state_in = ST_IDLE;
            end else if (!status.have_reference) begin
               cmd.set_reference = 1'b1;
               state_in          = ST_IDLE;
            end else if (status.recording) begin
               cmd.div_start    = 1'b1;
               cmd.div_operands = OP_LAUNCH_TO_SAMPLE;
               phase_in         = PH_RECORD;
               state_in         = ST_DIVIDE;
            end else begin
               cmd.div_start    = 1'b1;
               cmd.div_operands = OP_PREV_TO_SAMPLE;
               phase_in         = PH_TEST;
               state_in         = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               if (phase_ff == PH_TEST) begin
                  if (status.launch_hit) begin
                     // Launch seen: first record is for the previous sample.
                     cmd.set_recording = 1'b1;
                     cmd.div_start     = 1'b1;
                     cmd.div_operands  = OP_LAUNCH_TO_PREV;
                     phase_in          = PH_LAUNCH_FIRST;
                  end else begin
                     cmd.slide_reference = 1'b1;
                     state_in            = ST_IDLE;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = (phase_ff != PH_LAUNCH_FIRST);
               state_in      = (phase_ff == PH_LAUNCH_FIRST) ? ST_AFTER_FIRST : ST_IDLE;
            end
         end
         ST_AFTER_FIRST: begin
            if (status.halted) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_start    = 1'b1;
               cmd.div_operands = OP_LAUNCH_TO_SAMPLE;
               phase_in         = PH_LAUNCH_SECOND;
               state_in         = ST_DIVIDE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_TEST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* sv/pressure_launch_delta_recorder.sv */
`timescale 1ns / 1ps
// Top level of the pressure launch delta recorder: register port, controller and datapath.
//
//   Channel   Direction  Transfer condition            Contents
//   req_*     in         req_tvalid & req_tready       pressure sample in pascals
//   rsp_*     out        rsp_tvalid & rsp_tready       altitude delta record and flags
//   csr_*     in/out     psel & penable & pwrite       four configuration registers
//
// A sample either only sets the reference or meets a halted block, is tested and does not
// launch, gives one record while recording, or launches and gives two records. The controller
// takes no new sample until that work is done, and each quotient comes from the bit-serial
// divider, which runs one shift step per pressure bit and then raises its done strobe.
// Reset is synchronous and active high; it restores the register defaults and clears the
// control flags, altitude and record count. A new sample is taken while the last record still
// waits in the output register; a record that is ready while the previous one is still untaken
// holds the controller in its emit step until the result transfer frees the output register.

module pressure_launch_delta_recorder (
   input  logic                             clock,
   input  logic                             reset,
   // Sample input; tdata: [16:0] pressure, [23:17] zero
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,
   // Record output; tdata: [7:0] altitude_delta
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,
   output logic                             rsp_tlast,
   // tuser: [0] slow_rate, [1] store_full
   output logic [1:0]                       rsp_tuser,
   // Configuration register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pldr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pldr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pldr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import pldr_pkg::*;

   cfg_type       cfg_ff;
   csr_index_type csr_index;
   logic          csr_write;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   logic                  rsp_valid;
   logic [DELTA_W-1:0]    rsp_delta;
   logic                  rsp_last;
   logic                  rsp_slow;
   logic                  rsp_full;

   // The register port never stalls; each register sits on its own 32-bit word.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressure_step     <= PRESSURE_STEP_RESET;
         cfg_ff.start_threshold   <= START_THRESHOLD_RESET;
         cfg_ff.fast_record_count <= FAST_RECORD_COUNT_RESET;
         cfg_ff.store_capacity    <= STORE_CAPACITY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PRESSURE_STEP:     cfg_ff.pressure_step     <= csr_pwdata[STEP_W-1:0];
            CSR_START_THRESHOLD:   cfg_ff.start_threshold   <= csr_pwdata[STEP_W-1:0];
            CSR_FAST_RECORD_COUNT: cfg_ff.fast_record_count <= csr_pwdata[COUNT_W-1:0];
            CSR_STORE_CAPACITY:    cfg_ff.store_capacity    <= csr_pwdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Reads return the register value, zero extended to the bus width.
   always_comb begin
      case (csr_index)
         CSR_PRESSURE_STEP:
            csr_prdata = {{(CSR_DATA_W-STEP_W){1'b0}}, cfg_ff.pressure_step};
         CSR_START_THRESHOLD:
            csr_prdata = {{(CSR_DATA_W-STEP_W){1'b0}}, cfg_ff.start_threshold};
         CSR_FAST_RECORD_COUNT:
            csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, cfg_ff.fast_record_count};
         CSR_STORE_CAPACITY:
            csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, cfg_ff.store_capacity};
         default:
            csr_prdata = '0;
      endcase
   end

   // The controller owns sequencing; it sees the datapath only through the status struct.
   pldr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the references, running altitude and record count, the divider
   // and the output register that decouples record transfers from sample processing.
   pldr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg_ff),
      .req_pressure (req_tdata[PRESSURE_W-1:0]),
      .rsp_tready   (rsp_tready),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_delta    (rsp_delta),
      .rsp_last     (rsp_last),
      .rsp_slow     (rsp_slow),
      .rsp_full     (rsp_full)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = rsp_delta;
   assign rsp_tlast  = rsp_last;
   assign rsp_tuser  = {rsp_full, rsp_slow};

`ifndef SYNTHESIS
   // A record that fills the store always ends the run of its sample.
   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("store_full record without last_of_run");

   // Once the store is full the block stays halted until reset.
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("halted state dropped without reset");

   // A record is only loaded when the output register is free or being drained.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("record emitted over an untaken record");

   // No record is produced once the block has halted.
   a_no_emit_halted: assert property (@(posedge clock) disable iff (reset)
      status.halted |-> !cmd.emit)
      else $error("record emitted while halted");
`endif

endmodule
